[rtl/sccc_pkg.sv]
package sccc_pkg;

    localparam int unsigned SETS_DEF       = 256;
    localparam int unsigned WAYS_DEF       = 8;
    localparam int unsigned LINE_BYTES_DEF = 64;
    localparam int unsigned ADDR_BITS_DEF  = 32;

    // Action codes
    localparam logic [2:0] ACT_RD    = 3'd0;
    localparam logic [2:0] ACT_WR    = 3'd1;
    localparam logic [2:0] ACT_BRD   = 3'd2;
    localparam logic [2:0] ACT_BRDX  = 3'd3;
    localparam logic [2:0] ACT_BUPG  = 3'd4;
    localparam logic [2:0] ACT_PROBE = 3'd5;
    localparam logic [2:0] ACT_FILLS = 3'd6;
    localparam logic [2:0] ACT_FILLE = 3'd7;

    // Bus request codes
    localparam logic [2:0] BUS_NONE  = 3'd0;
    localparam logic [2:0] BUS_RD    = 3'd1;
    localparam logic [2:0] BUS_RDX   = 3'd2;
    localparam logic [2:0] BUS_PROBE = 3'd3;
    localparam logic [2:0] BUS_UPG   = 3'd4;
    localparam logic [2:0] BUS_RDXP  = 3'd5;

    // Line states
    localparam logic [2:0] ST_I = 3'd0;
    localparam logic [2:0] ST_S = 3'd1;
    localparam logic [2:0] ST_E = 3'd2;
    localparam logic [2:0] ST_O = 3'd3;
    localparam logic [2:0] ST_M = 3'd4;

    // Protocol codes
    localparam logic [1:0] PROT_MSI  = 2'd0;
    localparam logic [1:0] PROT_MESI = 2'd1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [2:0]  bus_request;
        logic        writeback;
        logic [31:0] victim_address;
        logic        flush;
        logic        intervention;
        logic        invalidation;
        logic        cache_transfer;
        logic [1:0]  copy_status;
        logic        copy_clean_exclusive;
    } t_rsp;

endpackage

[rtl/sccc_victim.sv]
// Victim select: first invalid way, else lowest stamp (highest way on tie).
module sccc_victim
    import sccc_pkg::*;
#(
    parameter int unsigned WAYS = WAYS_DEF,
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic [WAYS-1:0]       i_valid,
    input  logic [WAYS-1:0][31:0] i_stamp,
    output logic [WW-1:0]         o_way
);
    logic [WW-1:0] inv_way;
    logic          inv_any;
    logic [WW-1:0] lru_way;
    logic [31:0]   best;

    always_comb begin
        inv_way = '0;
        inv_any = 1'b0;
        lru_way = '0;
        best    = '1;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_valid[w]) begin
                inv_way = WW'(w);
                inv_any = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (i_stamp[w] <= best) begin
                best    = i_stamp[w];
                lru_way = WW'(w);
            end
        end
        o_way = inv_any ? inv_way : lru_way;
    end
endmodule

[rtl/snooping_coherent_cache_ctrl.sv]
// A result strobes after the memory read and then the update.
// Start is not taken while busy; busy is high in the update cycle,
// set by the read-modify-write of the set memories.
// Reset: synchronous; clears protocol and clock, then a clearing pass over all
// SETS rows marks every line invalid while busy and cfg ready hold off traffic.
// Results cannot be stalled by the receiver.
module snooping_coherent_cache_ctrl
    import sccc_pkg::*;
#(
    parameter int unsigned SETS       = SETS_DEF,
    parameter int unsigned WAYS       = WAYS_DEF,
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output logic       o_rsp_strobe,
    output t_rsp       o_rsp
);
    localparam int unsigned OFFB = $clog2(LINE_BYTES);
    localparam int unsigned SETB = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned SETR = $clog2(SETS);
    localparam int unsigned ABITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int unsigned TAGB = ABITS - OFFB - SETR;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Set memories: one row holds all ways
    logic [WAYS-1:0][TAGB-1:0] m_tag   [SETS];
    logic [WAYS-1:0][2:0]      m_st    [SETS];
    logic [WAYS-1:0][31:0]     m_stamp [SETS];

    logic [WAYS-1:0][TAGB-1:0] r_rtag;
    logic [WAYS-1:0][2:0]      r_rst;
    logic [WAYS-1:0][31:0]     r_rstamp;

    logic        r_busy;
    logic        r_clear;
    logic [SETB-1:0] r_clr;
    logic [2:0]  r_act;
    logic [31:0] r_addr;
    logic [1:0]  r_prot;
    logic [31:0] r_clock;
    logic        r_strobe;
    t_rsp        r_rsp;

    logic [31:0] amask_addr;
    logic [SETB-1:0] in_set, c_set;
    logic [TAGB-1:0] c_tag;

    assign amask_addr = i_req.address & 32'((64'd1 << ABITS) - 64'd1);
    assign in_set = (SETS > 1) ? SETB'(amask_addr >> OFFB) : '0;
    assign c_set  = (SETS > 1) ? SETB'(r_addr >> OFFB) : '0;
    assign c_tag  = TAGB'(r_addr >> (OFFB + SETR));

    assign busy         = r_busy | r_clear;
    assign o_cfg_ready  = !busy;
    assign o_rsp_strobe = r_strobe;
    assign o_rsp        = r_rsp;

    // Line states of the fetched row and the tag match
    logic [WAYS-1:0]      valid;
    logic [WAYS-1:0][2:0] est;
    logic [WAYS-1:0]      match;
    logic [WW-1:0]        hit_way, vic_way, tgt_way;
    logic                 found;
    logic [2:0]           st;

    always_comb begin
        hit_way = '0;
        found   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            est[w]   = r_rst[w];
            valid[w] = est[w] != ST_I;
            match[w] = valid[w] && r_rtag[w] == c_tag;
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WW'(w);
                found   = 1'b1;
            end
        end
        st = found ? est[hit_way] : ST_I;
    end

    sccc_victim #(.WAYS(WAYS)) u_victim (
        .i_valid (valid),
        .i_stamp (r_rstamp),
        .o_way   (vic_way)
    );

    // Compute the update and the result
    logic        msi, moesi;
    logic [31:0] clk_nx;
    logic        wr_en, wr_tag, wr_stamp;
    logic [2:0]  n_st;
    logic [31:0] n_stamp;
    t_rsp        n_rsp;
    logic        fill;
    logic [2:0]  fill_st;

    always_comb begin
        msi      = r_prot == PROT_MSI;
        moesi    = r_prot[1];
        clk_nx   = r_clock + 32'd1;
        wr_en    = 1'b0;
        wr_tag   = 1'b0;
        wr_stamp = 1'b0;
        n_st     = st;
        n_stamp  = r_clock;
        tgt_way  = hit_way;
        fill     = 1'b0;
        fill_st  = ST_S;
        n_rsp    = '0;
        case (r_act)
            ACT_RD, ACT_WR: begin
                n_stamp = clk_nx;
                if (found) begin
                    n_rsp.hit = 1'b1;
                    wr_en     = 1'b1;
                    wr_stamp  = 1'b1;
                    if (r_act == ACT_WR) begin
                        n_st = ST_M;
                        if (st == ST_S || st == ST_O)
                            n_rsp.bus_request = msi ? BUS_RDX : BUS_UPG;
                    end
                end else if (r_act == ACT_WR) begin
                    fill = 1'b1;
                    fill_st = ST_M;
                    n_rsp.bus_request = msi ? BUS_RDX : BUS_RDXP;
                end else if (msi) begin
                    fill = 1'b1;
                    n_rsp.bus_request = BUS_RD;
                end else begin
                    n_rsp.bus_request = BUS_PROBE;
                end
            end
            ACT_BRD: begin
                if (found) begin
                    if (st == ST_O) begin
                        n_rsp.flush = 1'b1;
                    end else if (st == ST_M) begin
                        n_rsp.flush = 1'b1;
                        wr_en = 1'b1;
                        if (moesi) begin
                            n_st = ST_O;
                        end else begin
                            n_st = ST_S;
                            n_rsp.intervention = 1'b1;
                        end
                    end else if (st == ST_E) begin
                        wr_en = 1'b1;
                        n_st = ST_S;
                        n_rsp.intervention = 1'b1;
                    end
                end
            end
            ACT_BRDX: begin
                if (found) begin
                    n_rsp.flush = st == ST_M || st == ST_O;
                    wr_en = 1'b1;
                    n_st = ST_I;
                    n_rsp.invalidation = 1'b1;
                end
            end
            ACT_BUPG: begin
                if (found && (st == ST_S || st == ST_O)) begin
                    wr_en = 1'b1;
                    n_st = ST_I;
                    n_rsp.invalidation = 1'b1;
                end
            end
            ACT_PROBE: begin
                if (found) begin
                    n_rsp.copy_status = (moesi && (st == ST_E || st == ST_M || st == ST_O))
                                        ? 2'd2 : 2'd1;
                    if (moesi)
                        n_rsp.copy_clean_exclusive = st == ST_E;
                    else if (r_prot == PROT_MESI)
                        n_rsp.copy_clean_exclusive = st == ST_E || st == ST_S;
                end
            end
            ACT_FILLS: begin
                fill = 1'b1;
                n_rsp.cache_transfer = !msi;
            end
            ACT_FILLE: begin
                fill = 1'b1;
                fill_st = ST_E;
            end
            default: begin
            end
        endcase
        // Allocate or refresh a line
        if (fill) begin
            wr_en    = 1'b1;
            wr_stamp = 1'b1;
            n_st     = fill_st;
            if (!found) begin
                tgt_way = vic_way;
                wr_tag  = 1'b1;
                if (est[vic_way] == ST_M || est[vic_way] == ST_O) begin
                    n_rsp.writeback = 1'b1;
                    n_rsp.victim_address = 32'(({32'd0, r_rtag[vic_way]} << (OFFB + SETR))
                        | (64'(c_set) << OFFB)) & ((SETS > 1) ? 32'hFFFF_FFFF
                        : 32'(({32'd0, r_rtag[vic_way]} << (OFFB + SETR))));
                end
            end
        end
    end

    // Memory read port: row read on start
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_rtag   <= m_tag[in_set];
            r_rst    <= m_st[in_set];
            r_rstamp <= m_stamp[in_set];
        end
    end

    // Clear one state row per cycle after reset, else write back the modified row
    always_ff @(posedge i_clk) begin
        if (r_clear) begin
            m_st[r_clr] <= '0;
        end else if (r_busy && wr_en) begin
            m_st[c_set][tgt_way] <= n_st;
            if (wr_tag)
                m_tag[c_set][tgt_way] <= c_tag;
            if (wr_stamp)
                m_stamp[c_set][tgt_way] <= n_stamp;
        end
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_clear  <= 1'b1;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_prot   <= PROT_MSI;
            r_clock  <= '0;
        end else begin
            r_strobe <= r_busy;
            if (i_cfg_valid && o_cfg_ready)
                r_prot <= i_cfg_data;
            if (r_clear) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == SETB'(SETS - 1))
                    r_clear <= 1'b0;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                if (r_act == ACT_RD || r_act == ACT_WR)
                    r_clock <= clk_nx;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    // Hold the transaction and the result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_act  <= i_req.action;
            r_addr <= amask_addr;
        end
        if (r_busy)
            r_rsp <= n_rsp;
    end
endmodule
